// File: hdl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular deque core.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int MaxEntries = 1024;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int DataW      = 32;
  localparam int ApbDataW   = 32;
  localparam int ApbAddrW   = 3;

  localparam logic [2:0] ActPushFront = 3'd0;
  localparam logic [2:0] ActPushBack  = 3'd1;
  localparam logic [2:0] ActPopFront  = 3'd2;
  localparam logic [2:0] ActPopBack   = 3'd3;
  localparam logic [2:0] ActNop       = 3'd4;

  localparam logic [DataW-1:0] EmptyValue = '1;

  typedef struct packed {
    logic [2:0]              action;
    logic signed [DataW-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic                    accepted;
    logic signed [DataW-1:0] front_value;
    logic signed [DataW-1:0] rear_value;
    logic                    is_empty;
    logic                    is_full;
  } out_t;

  typedef struct packed {
    logic            wr;
    logic [CntW-1:0] capacity;
  } cfg_t;

endpackage

`default_nettype wire

// File: hdl/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// File: hdl/cdq_cfg.sv
// ----------------------------------------------------------------------------
// cdq_cfg
// APB register block holding the clamped capacity register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cdq_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [cdq_pkg::ApbDataW-1:0]  pwdata,
  output logic      [cdq_pkg::ApbDataW-1:0]  prdata,
  output logic                               pready,
  output cdq_pkg::cfg_t                      cfg_o
);

  localparam logic [cdq_pkg::CntW-1:0] CapMax = cdq_pkg::CntW'(cdq_pkg::MaxEntries);

  logic                     sel_cap;
  logic                     wr_cap;
  logic [cdq_pkg::CntW-1:0] wval;
  logic [cdq_pkg::CntW-1:0] cap_d, cap_q;

  // only one register exists, selected while paddr[2] is clear; paddr[2] set is beyond the list
  assign sel_cap = !paddr[2];
  assign wr_cap  = psel && penable && pwrite && sel_cap;
  assign wval    = pwdata[cdq_pkg::CntW-1:0];

  always_comb begin
    cap_d = cap_q;
    if (wr_cap) begin
      if (wval == '0) begin
        cap_d = cdq_pkg::CntW'(1);
      end else if (wval > CapMax) begin
        cap_d = CapMax;
      end else begin
        cap_d = wval;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapMax;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign pready       = 1'b1;
  assign prdata       = sel_cap ? cdq_pkg::ApbDataW'(cap_q) : '0;
  assign cfg_o.wr       = wr_cap;
  assign cfg_o.capacity = cap_q;

endmodule

`default_nettype wire

// File: hdl/circular_deque_ring_buffer_core.sv
// ----------------------------------------------------------------------------
// circular_deque_ring_buffer_core
// Double-ended queue in a ring memory with an APB capacity register.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. busy then stays high
// through the Exec state, for the ring memory access (write for a push, read
// of the new end entry for a pop that leaves the deque non-empty), and the Fin
// state, for the memory read data to return. The result follows on result_o
// with done_o high for exactly one cycle, in the first cycle with busy low, and
// the next item may be started in that same cycle; no new item is taken while
// busy is high. The single-port ring memory has registered read data. The
// receiver cannot stall. The end values are kept in registers, so only a pop
// reads the ring. Writing capacity empties the deque; write it only while busy
// is low and no result is pending.
`default_nettype none

module circular_deque_ring_buffer_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  input  wire cdq_pkg::in_t                  item_i,
  output logic                               busy,
  output logic                               done_o,
  output cdq_pkg::out_t                      result_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cdq_pkg::ApbAddrW-1:0]  paddr,
  input  wire logic [cdq_pkg::ApbDataW-1:0]  pwdata,
  output logic      [cdq_pkg::ApbDataW-1:0]  prdata,
  output logic                               pready
);

  localparam int IdxW  = cdq_pkg::IdxW;
  localparam int CntW  = cdq_pkg::CntW;
  localparam int DataW = cdq_pkg::DataW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  cdq_pkg::cfg_t cfg;

  logic [1:0]       state_d, state_q;
  logic [2:0]       act_q;
  logic [DataW-1:0] val_q;
  logic [IdxW-1:0]  head_d, head_q, tail_d, tail_q;
  logic [CntW-1:0]  count_d, count_q;
  logic [DataW-1:0] front_d, front_q, rear_d, rear_q;
  logic             ok_d, ok_q;
  logic             rd_front_d, rd_front_q, rd_rear_d, rd_rear_q;
  logic             done_d, done_q;
  cdq_pkg::out_t    res_d, res_q;

  logic             mem_we;
  logic [IdxW-1:0]  mem_addr;
  logic [DataW-1:0] mem_rdata;

  logic             full, empty, is_push, is_pop;
  logic             now_empty;

  function automatic logic [IdxW-1:0] step_back(input logic [IdxW-1:0] i,
                                                input logic [CntW-1:0] cap);
    logic [CntW-1:0] last;
    last = cap - CntW'(1);
    return (i == '0) ? last[IdxW-1:0] : i - IdxW'(1);
  endfunction

  function automatic logic [IdxW-1:0] step_fwd(input logic [IdxW-1:0] i,
                                               input logic [CntW-1:0] cap);
    logic [CntW-1:0] nxt;
    nxt = {1'b0, i} + CntW'(1);
    return (nxt == cap) ? '0 : nxt[IdxW-1:0];
  endfunction

  cdq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cdq_ram #(
    .Width (DataW),
    .Depth (cdq_pkg::MaxEntries)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (val_q),
    .rdata_o (mem_rdata)
  );

  assign full    = count_q >= cfg.capacity;
  assign empty   = count_q == '0;
  assign is_push = act_q inside {cdq_pkg::ActPushFront, cdq_pkg::ActPushBack};
  assign is_pop  = act_q inside {cdq_pkg::ActPopFront, cdq_pkg::ActPopBack};
  assign now_empty = count_q == '0;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    front_d    = front_q;
    rear_d     = rear_q;
    ok_d       = ok_q;
    rd_front_d = rd_front_q;
    rd_rear_d  = rd_rear_q;
    done_d     = 1'b0;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_addr   = head_q;

    case (state_q)
      StIdle: begin
        if (start) begin
          state_d = StExec;
        end
      end
      StExec: begin
        ok_d       = 1'b0;
        rd_front_d = 1'b0;
        rd_rear_d  = 1'b0;
        if (is_push && !full) begin
          ok_d    = 1'b1;
          mem_we  = 1'b1;
          count_d = count_q + CntW'(1);
          if (empty) begin
            head_d   = '0;
            tail_d   = '0;
            mem_addr = '0;
            front_d  = val_q;
            rear_d   = val_q;
          end else if (act_q == cdq_pkg::ActPushFront) begin
            head_d   = step_back(head_q, cfg.capacity);
            mem_addr = head_d;
            front_d  = val_q;
          end else begin
            tail_d   = step_fwd(tail_q, cfg.capacity);
            mem_addr = tail_d;
            rear_d   = val_q;
          end
        end else if (is_pop && !empty) begin
          ok_d    = 1'b1;
          count_d = count_q - CntW'(1);
          // the new end entry comes back from the ring next cycle
          if (count_q > CntW'(1)) begin
            if (act_q == cdq_pkg::ActPopFront) begin
              head_d     = step_fwd(head_q, cfg.capacity);
              mem_addr   = head_d;
              rd_front_d = 1'b1;
            end else begin
              tail_d    = step_back(tail_q, cfg.capacity);
              mem_addr  = tail_d;
              rd_rear_d = 1'b1;
            end
          end
        end
        state_d = StFin;
      end
      StFin: begin
        if (rd_front_q) begin
          front_d = mem_rdata;
        end
        if (rd_rear_q) begin
          rear_d = mem_rdata;
        end
        res_d.accepted    = ok_q;
        res_d.is_empty    = now_empty;
        res_d.is_full     = count_q == cfg.capacity;
        res_d.front_value = now_empty ? cdq_pkg::EmptyValue : front_d;
        res_d.rear_value  = now_empty ? cdq_pkg::EmptyValue : rear_d;
        done_d  = 1'b1;
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // capacity write empties the deque, the ring contents stay
    if (cfg.wr) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      ok_q       <= 1'b0;
      rd_front_q <= 1'b0;
      rd_rear_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      ok_q       <= ok_d;
      rd_front_q <= rd_front_d;
      rd_rear_q  <= rd_rear_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      act_q <= item_i.action;
      val_q <= item_i.push_value;
    end
    front_q <= front_d;
    rear_q  <= rear_d;
    res_q   <= res_d;
  end

  assign busy     = state_q != StIdle;
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// File: hdl/cdq_checker.sv
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks of the circular deque core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          done_o,
  input wire cdq_pkg::out_t result_o
);

  // a transfer in always occupies the core for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("core not busy after start");

  // the result shows only once the core has gone idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // a result strobe only ends a busy period
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without an item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.is_empty |->
      result_o.front_value == cdq_pkg::EmptyValue &&
      result_o.rear_value == cdq_pkg::EmptyValue && !result_o.is_full)
    else $error("empty deque reports end values or full");

endmodule

bind circular_deque_ring_buffer_core cdq_checker u_cdq_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire
